>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Short forms for the concurrent checks used by the RTC calendar checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define RTC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rtc calendar check failed");

// Next-cycle implication, off while reset is high.
`define RTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rtc calendar check failed");

// Next-cycle implication that also runs during reset.
`define RTC_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rtc calendar check failed");

`endif

>>> sv/rtcdst_pkg.sv
// ----------------------------------------------------------------------------
// rtcdst_pkg
// Types, constants and calendar helpers shared by the RTC calendar block.
// ----------------------------------------------------------------------------
package rtcdst_pkg;

  localparam logic [5:0] SEC_MAX     = 6'd59;
  localparam logic [5:0] MIN_MAX     = 6'd59;
  localparam logic [4:0] HOUR_MAX    = 5'd23;
  localparam logic [2:0] WEEKDAY_MAX = 3'd6;
  localparam logic [2:0] SUNDAY      = 3'd0;
  localparam logic [3:0] MONTH_FEB   = 4'd1;
  localparam logic [3:0] MONTH_MAR   = 4'd2;
  localparam logic [3:0] MONTH_OCT   = 4'd9;
  localparam logic [3:0] MONTH_DEC   = 4'd11;
  localparam logic [6:0] YEAR_MAX    = 7'd99;
  // offset of 2100, the only century year in range that is not a leap year
  localparam logic [6:0] YEAR_CENTURY = 7'd100;
  localparam logic [4:0] DST_HOUR    = 5'd2;
  localparam logic [4:0] LEN_FEB     = 5'd28;
  localparam logic [4:0] LEN_SHORT   = 5'd30;
  localparam logic [4:0] LEN_LONG    = 5'd31;
  localparam logic [5:0] WEEK_DAYS   = 6'd7;

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
    logic [2:0] weekday;
    logic       leap;
  } rtc_time_t;

  typedef struct packed {
    rtc_time_t t;
    logic      dst_done;
  } rtc_state_t;

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
    logic [2:0] weekday;
  } rtc_load_t;

  typedef struct packed {
    rtc_time_t t;
    logic      dst_applied;
    logic      minute_pulse;
  } rtc_result_t;

  // Days in a month; anything past December counts as a long month.
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    unique case (m)
      4'd1:                      len = LEN_FEB;
      4'd3, 4'd5, 4'd8, 4'd10:   len = LEN_SHORT;
      default:                   len = LEN_LONG;
    endcase
    return len;
  endfunction

  // Year 2000 + yr, yr below 128: every fourth year but 2100.
  function automatic logic leap_of(input logic [6:0] yr);
    return (yr[1:0] == 2'b00) && (yr != YEAR_CENTURY);
  endfunction

endpackage

>>> sv/rtcdst_next.sv
// ----------------------------------------------------------------------------
// rtcdst_next
// Next-state logic: one second tick or a load, with day rollover and DST.
// ----------------------------------------------------------------------------
module rtcdst_next import rtcdst_pkg::*; (
  input  rtc_state_t  state,
  input  logic        func,
  input  rtc_load_t   load,
  output rtc_state_t  state_next,
  output rtc_result_t result
);

  logic [4:0] len;
  logic [4:0] hour_inc;
  logic       dst_hit;
  logic       dst_now;
  logic       pulse;

  assign len      = month_len(state.t.month);
  assign hour_inc = state.t.hour + 5'd1;
  assign dst_hit  = (hour_inc == DST_HOUR) && !state.dst_done &&
                    (({1'b0, state.t.day} + WEEK_DAYS) > {1'b0, len}) &&
                    (state.t.weekday == SUNDAY);

  always_comb begin
    state_next = state;
    dst_now    = 1'b0;
    pulse      = 1'b0;
    if (func) begin
      state_next.t.sec     = load.sec;
      state_next.t.min     = load.min;
      state_next.t.hour    = load.hour;
      state_next.t.day     = load.day;
      state_next.t.month   = load.month;
      state_next.t.year    = load.year;
      state_next.t.weekday = load.weekday;
      state_next.t.leap    = leap_of(load.year);
    end else if (state.t.sec < SEC_MAX) begin
      state_next.t.sec = state.t.sec + 6'd1;
    end else begin
      state_next.t.sec = '0;
      if (state.t.min < MIN_MAX) begin
        state_next.t.min = state.t.min + 6'd1;
        pulse            = 1'b1;
      end else begin
        state_next.t.min = '0;
        if (state.t.hour < HOUR_MAX) begin
          state_next.t.hour = hour_inc;
          if (dst_hit) begin
            // spring back in March, forward in October, else hours stay
            if (state.t.month == MONTH_MAR) begin
              state_next.t.hour = hour_inc - 5'd1;
            end else if (state.t.month == MONTH_OCT) begin
              state_next.t.hour = hour_inc + 5'd1;
            end
            state_next.dst_done = 1'b1;
            dst_now             = 1'b1;
          end
        end else begin
          state_next.t.hour   = '0;
          state_next.dst_done = 1'b0;
          state_next.t.weekday = (state.t.weekday < WEEKDAY_MAX) ?
                                 state.t.weekday + 3'd1 : SUNDAY;
          if (len == LEN_FEB) begin
            if ((state.t.day < LEN_FEB) || ((state.t.day == LEN_FEB) && state.t.leap)) begin
              state_next.t.day = state.t.day + 5'd1;
            end else begin
              state_next.t.day   = 5'd1;
              state_next.t.month = state.t.month + 4'd1;
            end
          end else if (len == LEN_LONG) begin
            if (state.t.day < LEN_LONG) begin
              state_next.t.day = state.t.day + 5'd1;
            end else begin
              state_next.t.day = 5'd1;
              if (state.t.month >= MONTH_DEC) begin
                state_next.t.month = '0;
                state_next.t.year  = (state.t.year >= YEAR_MAX) ? '0 :
                                     state.t.year + 7'd1;
                state_next.t.leap  = leap_of(state_next.t.year);
              end else begin
                state_next.t.month = state.t.month + 4'd1;
              end
            end
          end else begin
            if (state.t.day < LEN_SHORT) begin
              state_next.t.day = state.t.day + 5'd1;
            end else begin
              state_next.t.day   = 5'd1;
              state_next.t.month = state.t.month + 4'd1;
            end
          end
        end
      end
    end
  end

  assign result.t            = state_next.t;
  assign result.dst_applied  = dst_now;
  assign result.minute_pulse = pulse;

endmodule

>>> sv/rtc_calendar_with_dst_unit.sv
// ----------------------------------------------------------------------------
// rtc_calendar_with_dst_unit
// Real-time clock calendar with last-Sunday daylight-saving correction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): func = 0 advances the clock one
//   second, func = 1 loads the date and time from the load_* fields and
//   derives the leap flag from the year.
//   Output channel (out_valid/out_ready): one result per input transfer,
//   carrying the calendar after that item plus dst_applied and minute_pulse.
//   Latency: a result is valid the cycle after its input transfer unless it
//   lands in the skid register. Throughput: one item per cycle while
//   in_ready is high; the calendar counters update in the same cycle as the
//   transfer, so items chain back to back. Stall: results sit in an output
//   register backed by a one-entry skid register; in_ready drops only when
//   both hold results, and rises again as soon as the receiver takes one.
//   Reset: all calendar counters, the leap and DST-done flags clear to zero
//   and both result registers empty.
// ----------------------------------------------------------------------------
module rtc_calendar_with_dst_unit import rtcdst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       func,
  input  logic [5:0] load_seconds,
  input  logic [5:0] load_minutes,
  input  logic [4:0] load_hours,
  input  logic [4:0] load_day,
  input  logic [3:0] load_month,
  input  logic [6:0] load_year,
  input  logic [2:0] load_weekday,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] seconds,
  output logic [5:0] minutes,
  output logic [4:0] hours,
  output logic [4:0] day,
  output logic [3:0] month,
  output logic [6:0] year,
  output logic [2:0] weekday,
  output logic       leap_year,
  output logic       dst_applied,
  output logic       minute_pulse
);

  rtc_state_t  state;
  rtc_state_t  state_next;
  rtc_load_t   load;
  rtc_result_t result;
  rtc_result_t out_reg;
  rtc_result_t skid;
  logic        skid_valid;
  logic        in_xfer;
  logic        out_xfer;

  assign load.sec     = load_seconds;
  assign load.min     = load_minutes;
  assign load.hour    = load_hours;
  assign load.day     = load_day;
  assign load.month   = load_month;
  assign load.year    = load_year;
  assign load.weekday = load_weekday;

  rtcdst_next u_next (
    .state      (state),
    .func       (func),
    .load       (load),
    .state_next (state_next),
    .result     (result)
  );

  // skid empty means there is room for one more result
  assign in_ready = !skid_valid;
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // calendar state moves only on an input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_xfer) begin
      state <= state_next;
    end
  end

  // output register plus skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_xfer) begin
        skid_valid <= 1'b0;
      end
    end else if (in_xfer) begin
      if (!out_valid || out_xfer) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_xfer) begin
        out_reg <= skid;
      end
    end else if (in_xfer) begin
      if (!out_valid || out_xfer) begin
        out_reg <= result;
      end else begin
        skid <= result;
      end
    end
  end

  assign seconds      = out_reg.t.sec;
  assign minutes      = out_reg.t.min;
  assign hours        = out_reg.t.hour;
  assign day          = out_reg.t.day;
  assign month        = out_reg.t.month;
  assign year         = out_reg.t.year;
  assign weekday      = out_reg.t.weekday;
  assign leap_year    = out_reg.t.leap;
  assign dst_applied  = out_reg.dst_applied;
  assign minute_pulse = out_reg.minute_pulse;

endmodule

>>> sv/rtcdst_checker.sv
// ----------------------------------------------------------------------------
// rtcdst_checker
// Port-level checks for the RTC calendar block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtcdst_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] seconds,
  input logic [5:0] minutes,
  input logic [4:0] hours,
  input logic [2:0] weekday,
  input logic       dst_applied,
  input logic       minute_pulse
);

  // no result may appear right after reset
  `RTC_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, rst, !out_valid)

  // a stalled result holds
  `RTC_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(seconds) && $stable(minutes) && $stable(hours))

  // minute pulse comes only from a seconds wrap into a nonzero minute
  `RTC_ASSERT_NOW(a_pulse_form, clk, rst, out_valid && minute_pulse,
    seconds == 6'd0 && minutes != 6'd0 && !dst_applied)

  // DST correction fires only at the top of an hour on a Sunday
  `RTC_ASSERT_NOW(a_dst_form, clk, rst, out_valid && dst_applied,
    seconds == 6'd0 && minutes == 6'd0 && weekday == 3'd0 &&
    (hours == 5'd1 || hours == 5'd2 || hours == 5'd3))

endmodule

bind rtc_calendar_with_dst_unit rtcdst_checker u_rtcdst_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .seconds      (seconds),
  .minutes      (minutes),
  .hours        (hours),
  .weekday      (weekday),
  .dst_applied  (dst_applied),
  .minute_pulse (minute_pulse)
);
